[rtl/core/ssff_pkg.sv]
`default_nettype none

package ssff_pkg;

  // Walk phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_SKIP    = 3'd3,
    PH_SCAN    = 3'd4,
    PH_DATA    = 3'd5,
    PH_STRINGS = 3'd6,
    PH_INDEX   = 3'd7
  } phase_t;

  // Result outcome codes
  typedef enum logic [1:0] {
    OUT_WALKING   = 2'd0,
    OUT_FOUND     = 2'd1,
    OUT_NOT_FOUND = 2'd2
  } outcome_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_QUERY_KIND      = 3'd0,
    REG_TARGET_TYPE     = 3'd1,
    REG_FIELD_OFFSET    = 3'd2,
    REG_FIELD_LENGTH    = 3'd3,
    REG_TABLE_LENGTH    = 3'd4,
    REG_STRUCTURE_COUNT = 3'd5
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  END_MARK_TYPE = 8'd127;
  localparam logic [17:0] MIN_LEFT      = 18'd6;
  localparam logic [7:0]  MIN_OFFSET    = 8'd2;
  localparam logic [7:0]  MIN_LENGTH    = 8'd4;

  localparam logic        QUERY_DATA    = 1'b0;

endpackage

`default_nettype wire

[rtl/core/ssff_in_if.sv]
`default_nettype none

interface ssff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       first_byte;

  modport source (output valid, output table_byte, output first_byte, input ready);
  modport sink   (input valid, input table_byte, input first_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/ssff_out_if.sv]
`default_nettype none

interface ssff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] outcome;
  logic       done_res;

  modport source (output valid, output out_byte, output byte_valid, output outcome,
                  output done_res, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input outcome,
                  input done_res, output ready);
endinterface

`default_nettype wire

[rtl/core/ssff_cfg_if.sv]
`default_nettype none

interface ssff_cfg_if;
  import ssff_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/smbios_structure_field_finder.sv]
// SMBIOS structure table walker. The table streams in on item_in, one byte per
// item in address order; first_byte marks offset zero and starts a new walk
// (dropping any walk in progress). Results leave on item_out: each returned
// field byte or string character is one item, and the walk closes with one
// item carrying done_res and outcome found or not found.
// The query is set on cfg (query kind, target type, field offset, field
// length, table length, structure count); cfg is always ready and its
// registers are read live by the walk.
// Every byte is handled as it is taken: the walk state is updated and any
// result is loaded into the output register at the edge the byte is taken,
// so results appear in the cycle after their byte. One byte per cycle is
// sustained while results are taken; the single output register sets this rate.
// When the receiver stalls, the waiting result holds and item_in.ready drops
// until it is taken; a byte arriving as the held result is taken is accepted
// in the same cycle.
// Reset (rst, synchronous) empties the output register, ends any walk and
// restores the register defaults (offset 2, length 1, all else zero).
`default_nettype none

module smbios_structure_field_finder (
  input  wire          clk,
  input  wire          rst,
  ssff_in_if.sink      item_in,
  ssff_out_if.source   item_out,
  ssff_cfg_if.sink     cfg
);
  import ssff_pkg::*;

  // Configuration registers
  logic        query_kind;
  logic [7:0]  target_type;
  logic [7:0]  field_offset;
  logic [7:0]  field_length;
  logic [15:0] table_length;
  logic [15:0] structure_count;

  // Walk state and next values
  phase_t      walk_phase, walk_phase_next;
  logic [16:0] table_offset, table_offset_next;
  logic [15:0] structures_left, structures_left_next;
  logic [7:0]  position_in_structure, position_in_structure_next;
  logic [7:0]  structure_type, structure_type_next;
  logic [7:0]  structure_length, structure_length_next;
  logic [7:0]  string_number, string_number_next;
  logic        previous_byte_zero, previous_byte_zero_next;
  logic        walk_done, walk_done_next;

  // Output register
  logic        res_valid;
  logic [7:0]  res_byte;
  logic        res_byte_valid;
  outcome_t    res_outcome;
  logic        res_done;

  // Per-byte working values
  logic        in_take;
  logic [7:0]  b;
  logic [8:0]  fend;
  logic [8:0]  pos_inc;
  logic [16:0] cur_offset;
  phase_t      cur_phase;
  logic        cur_done;
  logic [7:0]  cur_pos;
  logic        fin;
  outcome_t    fin_outcome;
  logic        fin_byte_valid;
  logic        put;
  logic        hit;
  logic        field_hit;
  logic        field_last;
  logic        gen_valid;
  logic [7:0]  gen_byte;
  logic        gen_byte_valid;
  outcome_t    gen_outcome;
  logic        gen_done;

  function automatic logic can_start(input logic [17:0] off, input logic [15:0] tl,
                                     input logic [15:0] left);
    can_start = (off + MIN_LEFT <= {2'b00, tl}) && (left != 16'd0);
  endfunction

  assign cfg.ready     = 1'b1;
  assign in_take       = item_in.valid && item_in.ready;
  assign item_in.ready = !res_valid || item_out.ready;
  assign b             = item_in.table_byte;
  assign fend          = {1'b0, field_offset} + {1'b0, field_length};

  // Take the state as it stands after a possible restart
  assign cur_offset = item_in.first_byte ? 17'd0 : table_offset;
  assign cur_phase  = item_in.first_byte ? PH_TYPE : walk_phase;
  assign cur_done   = item_in.first_byte ? 1'b0 : walk_done;
  assign cur_pos    = item_in.first_byte ? 8'd0 : position_in_structure;
  assign pos_inc    = {1'b0, cur_pos} + 9'd1;
  assign field_hit  = (cur_pos >= field_offset) && ({1'b0, cur_pos} < fend);
  assign field_last = ((cur_pos >= field_offset) && (pos_inc >= fend)) ||
                      (pos_inc >= {1'b0, structure_length});
  assign hit        = (structure_type == target_type) &&
                      ((query_kind == QUERY_DATA) ? (fend <= {1'b0, b})
                                                  : (field_offset < b));

  // Advance the walk by one table byte
  always_comb begin
    walk_phase_next            = walk_phase;
    table_offset_next          = table_offset;
    structures_left_next       = structures_left;
    position_in_structure_next = position_in_structure;
    structure_type_next        = structure_type;
    structure_length_next      = structure_length;
    string_number_next         = string_number;
    previous_byte_zero_next    = previous_byte_zero;
    walk_done_next             = walk_done;
    fin                        = 1'b0;
    fin_outcome                = OUT_NOT_FOUND;
    fin_byte_valid             = 1'b0;
    put                        = 1'b0;

    if (item_in.first_byte) begin
      walk_done_next             = 1'b0;
      table_offset_next          = 17'd0;
      structures_left_next       = structure_count;
      walk_phase_next            = PH_TYPE;
      position_in_structure_next = 8'd0;
    end

    if (item_in.first_byte && ((field_offset < MIN_OFFSET) ||
        !can_start(18'd0, table_length, structure_count))) begin
      fin = 1'b1;
    end else if (!cur_done) begin
      table_offset_next = cur_offset + 17'd1;
      case (cur_phase)
        PH_TYPE: begin
          if (b == END_MARK_TYPE) begin
            fin = 1'b1;
          end else begin
            structures_left_next       = structures_left_next - 16'd1;
            structure_type_next        = b;
            position_in_structure_next = 8'd1;
            walk_phase_next            = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < MIN_LENGTH) begin
            fin = 1'b1;
          end else begin
            structure_length_next      = b;
            position_in_structure_next = 8'd2;
            if (hit && query_kind == QUERY_DATA) begin
              if (field_length == 8'd0) begin
                fin         = 1'b1;
                fin_outcome = OUT_FOUND;
              end else begin
                walk_phase_next = PH_DATA;
              end
            end else if (hit) begin
              string_number_next = 8'd0;
              walk_phase_next    = PH_INDEX;
            end else begin
              walk_phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP, PH_INDEX, PH_DATA: begin
          if (cur_phase == PH_DATA && field_last) begin
            fin            = 1'b1;
            fin_outcome    = OUT_FOUND;
            fin_byte_valid = field_hit;
          end else if (cur_phase == PH_INDEX && cur_pos == field_offset && b == 8'd0) begin
            fin = 1'b1;
          end else begin
            put = (cur_phase == PH_DATA) && field_hit;
            if (cur_phase == PH_INDEX && cur_pos == field_offset) begin
              string_number_next = b;
            end
            position_in_structure_next = pos_inc[7:0];
            if (pos_inc >= {1'b0, structure_length}) begin
              if (cur_phase == PH_INDEX) begin
                walk_phase_next         = PH_STRINGS;
                previous_byte_zero_next = 1'b1;
              end else begin
                walk_phase_next            = PH_SCAN;
                position_in_structure_next = 8'd0;
              end
            end
          end
        end
        PH_SCAN: begin
          if (cur_pos != 8'd0 && previous_byte_zero && b == 8'd0) begin
            if (!can_start({1'b0, cur_offset} + 18'd1, table_length, structures_left)) begin
              fin = 1'b1;
            end else begin
              walk_phase_next            = PH_TYPE;
              position_in_structure_next = 8'd0;
            end
          end else if ({1'b0, cur_offset} + 18'd2 > {2'b00, table_length}) begin
            fin = 1'b1;
          end else begin
            previous_byte_zero_next    = (b == 8'd0);
            position_in_structure_next = 8'd1;
          end
        end
        PH_STRINGS: begin
          if (string_number == 8'd0 || cur_offset >= {1'b0, table_length}) begin
            fin = 1'b1;
          end else if (string_number > 8'd1) begin
            if (previous_byte_zero && b == 8'd0) begin
              fin = 1'b1;
            end else if (b == 8'd0) begin
              string_number_next      = string_number - 8'd1;
              previous_byte_zero_next = 1'b1;
            end else begin
              previous_byte_zero_next = 1'b0;
            end
          end else if (b == 8'd0) begin
            fin         = 1'b1;
            fin_outcome = OUT_FOUND;
          end else begin
            previous_byte_zero_next = 1'b0;
            put                     = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end

    if (fin) begin
      walk_done_next  = 1'b1;
      walk_phase_next = PH_IDLE;
    end
  end

  // Form the result of this byte
  always_comb begin
    gen_valid      = fin || put;
    gen_byte_valid = fin ? fin_byte_valid : put;
    gen_byte       = gen_byte_valid ? b : 8'd0;
    gen_outcome    = fin ? fin_outcome : OUT_WALKING;
    gen_done       = fin;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      query_kind      <= 1'b0;
      target_type     <= 8'd0;
      field_offset    <= 8'd2;
      field_length    <= 8'd1;
      table_length    <= 16'd0;
      structure_count <= 16'd0;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_QUERY_KIND:      query_kind      <= cfg.data[0];
        REG_TARGET_TYPE:     target_type     <= cfg.data[7:0];
        REG_FIELD_OFFSET:    field_offset    <= cfg.data[7:0];
        REG_FIELD_LENGTH:    field_length    <= cfg.data[7:0];
        REG_TABLE_LENGTH:    table_length    <= cfg.data;
        REG_STRUCTURE_COUNT: structure_count <= cfg.data;
        default: ;
      endcase
    end
  end

  // Walk state register
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_phase            <= PH_IDLE;
      table_offset          <= 17'd0;
      structures_left       <= 16'd0;
      position_in_structure <= 8'd0;
      structure_type        <= 8'd0;
      structure_length      <= 8'd0;
      string_number         <= 8'd0;
      previous_byte_zero    <= 1'b0;
      walk_done             <= 1'b1;
    end else if (in_take) begin
      walk_phase            <= walk_phase_next;
      table_offset          <= table_offset_next;
      structures_left       <= structures_left_next;
      position_in_structure <= position_in_structure_next;
      structure_type        <= structure_type_next;
      structure_length      <= structure_length_next;
      string_number         <= string_number_next;
      previous_byte_zero    <= previous_byte_zero_next;
      walk_done             <= walk_done_next;
    end
  end

  // Output register: load on a taken byte, drop when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_take) begin
      res_valid <= gen_valid;
    end else if (item_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_byte       <= gen_byte;
      res_byte_valid <= gen_byte_valid;
      res_outcome    <= gen_outcome;
      res_done       <= gen_done;
    end
  end

  assign item_out.valid      = res_valid;
  assign item_out.out_byte   = res_byte;
  assign item_out.byte_valid = res_byte_valid;
  assign item_out.outcome    = res_outcome;
  assign item_out.done_res   = res_done;

endmodule

`default_nettype wire

[rtl/core/ssff_checker.sv]
`default_nettype none

module ssff_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       byte_valid,
  input wire [1:0] outcome,
  input wire       done_res
);
  import ssff_pkg::*;

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(outcome)
                                && $stable(done_res) && $stable(byte_valid))
    else $error("stalled result changed");

  // Only the final item carries an outcome other than walking
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (done_res == (outcome != OUT_WALKING)))
    else $error("outcome does not match done_res");

  // An item that is not final always carries a byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> byte_valid)
    else $error("intermediate item without a byte");

  // Reset empties the output, and input is refused only while a result waits
  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output not empty after reset");

  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a stalled result");

endmodule

bind smbios_structure_field_finder ssff_checker u_ssff_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (item_in.ready),
  .out_valid  (item_out.valid),
  .out_ready  (item_out.ready),
  .out_byte   (item_out.out_byte),
  .byte_valid (item_out.byte_valid),
  .outcome    (item_out.outcome),
  .done_res   (item_out.done_res)
);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
  import ssff_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    outcome_t   verdict;
    logic       last;
  } lookup_reply_t;

  typedef struct {
    logic        string_mode;
    logic [7:0]  type_id;
    logic [7:0]  offset;
    logic [7:0]  field_len;
    logic [15:0] table_len;
    logic [15:0] count;
  } query_t;

  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssff_in_if  in_ch ();
  ssff_out_if out_ch ();
  ssff_cfg_if cfg_ch ();

  smbios_structure_field_finder DUT (
    .clk      (clk),
    .rst      (rst),
    .item_in  (in_ch),
    .item_out (out_ch),
    .cfg      (cfg_ch)
  );

  // Query as the block sees it, and the walk that follows it
  query_t        cur_query;
  phase_t        walk_ph;
  logic [16:0]   walk_off;
  logic [15:0]   structs_left;
  logic [7:0]    struct_pos;
  logic [7:0]    struct_kind;
  logic [7:0]    struct_len;
  logic [7:0]    wanted_string;
  logic          last_was_nul;
  logic          walk_over;
  lookup_reply_t lookup_replies[$];

  int walked_bytes = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int receiver_hold_req = 0;
  int receiver_hold_left = 0;

  logic [7:0] table_buf[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- walk model

  task automatic reset_walk();
    cur_query.string_mode = 1'b0;
    cur_query.type_id = 8'd0;
    cur_query.offset = 8'd2;
    cur_query.field_len = 8'd1;
    cur_query.table_len = 16'd0;
    cur_query.count = 16'd0;
    walk_ph = PH_IDLE;
    walk_off = '0;
    structs_left = '0;
    struct_pos = '0;
    struct_kind = '0;
    struct_len = '0;
    wanted_string = '0;
    last_was_nul = 1'b0;
    walk_over = 1'b1;
    lookup_replies.delete();
  endtask

  task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] v);
    case (reg_index_t'(idx))
      REG_QUERY_KIND:      cur_query.string_mode = v[0];
      REG_TARGET_TYPE:     cur_query.type_id = v[7:0];
      REG_FIELD_OFFSET:    cur_query.offset = v[7:0];
      REG_FIELD_LENGTH:    cur_query.field_len = v[7:0];
      REG_TABLE_LENGTH:    cur_query.table_len = v;
      REG_STRUCTURE_COUNT: cur_query.count = v;
      default: ;
    endcase
  endtask

  // A new structure needs six bytes of table left and a count still running
  function automatic logic room_for_struct(input int unsigned off);
    return (off + 6 <= 32'(cur_query.table_len)) && (structs_left != 16'd0);
  endfunction

  task automatic post(input logic [7:0] b, input logic ok, input outcome_t v, input logic fin);
    lookup_reply_t r;
    r.data = ok ? b : 8'd0;
    r.data_ok = ok;
    r.verdict = v;
    r.last = fin;
    lookup_replies.push_back(r);
  endtask

  task automatic end_walk(input logic [7:0] b, input logic ok, input outcome_t v);
    walk_over = 1'b1;
    walk_ph = PH_IDLE;
    post(b, ok, v, 1'b1);
  endtask

  // Advance the walk by one table byte and queue the results it gives
  task automatic walk_byte(input logic [7:0] b, input logic start);
    int unsigned a, base, fend, tl, pos;
    logic hit, ok, fin;
    base = 32'(cur_query.offset);
    fend = 32'(cur_query.offset) + 32'(cur_query.field_len);
    tl = 32'(cur_query.table_len);
    walked_bytes++;
    if (start) begin
      walk_over = 1'b0;
      walk_off = '0;
      structs_left = cur_query.count;
      walk_ph = PH_TYPE;
      struct_pos = '0;
      if (cur_query.offset < MIN_OFFSET || !room_for_struct(0)) begin
        end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
        return;
      end
    end
    if (walk_over) return;
    a = 32'(walk_off);
    case (walk_ph)
      PH_TYPE: begin
        if (b == END_MARK_TYPE) begin
          end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
          return;
        end
        structs_left--;
        struct_kind = b;
        struct_pos = 8'd1;
        walk_ph = PH_LEN;
      end
      PH_LEN: begin
        if (b < MIN_LENGTH) begin
          end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
          return;
        end
        struct_len = b;
        struct_pos = 8'd2;
        hit = (struct_kind == cur_query.type_id) &&
              (cur_query.string_mode ? (base < 32'(b)) : (fend <= 32'(b)));
        if (hit && !cur_query.string_mode) begin
          if (cur_query.field_len == 8'd0) begin
            end_walk(8'd0, 1'b0, OUT_FOUND);
            return;
          end
          walk_ph = PH_DATA;
        end else if (hit) begin
          wanted_string = 8'd0;
          walk_ph = PH_INDEX;
        end else begin
          walk_ph = PH_SKIP;
        end
      end
      PH_SKIP, PH_INDEX, PH_DATA: begin
        pos = 32'(struct_pos);
        if (walk_ph == PH_DATA) begin
          ok = (pos >= base) && (pos < fend);
          fin = ((pos >= base) && (pos + 1 >= fend)) || (pos + 1 >= 32'(struct_len));
          if (fin) begin
            end_walk(b, ok, OUT_FOUND);
            return;
          end
          if (ok) post(b, 1'b1, OUT_WALKING, 1'b0);
        end else if (walk_ph == PH_INDEX && pos == base) begin
          if (b == 8'd0) begin
            end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
            return;
          end
          wanted_string = b;
        end
        pos++;
        struct_pos = pos[7:0];
        if (pos >= 32'(struct_len)) begin
          if (walk_ph == PH_INDEX) begin
            walk_ph = PH_STRINGS;
            last_was_nul = 1'b1;
          end else begin
            walk_ph = PH_SCAN;
            struct_pos = 8'd0;
          end
        end
      end
      PH_SCAN: begin
        if (struct_pos != 8'd0 && last_was_nul && b == 8'd0) begin
          if (!room_for_struct(a + 1)) begin
            end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
            return;
          end
          walk_ph = PH_TYPE;
          struct_pos = 8'd0;
        end else begin
          if (a + 2 > tl) begin
            end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
            return;
          end
          last_was_nul = (b == 8'd0);
          struct_pos = 8'd1;
        end
      end
      PH_STRINGS: begin
        if (wanted_string == 8'd0 || a >= tl) begin
          end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
          return;
        end
        if (wanted_string > 8'd1) begin
          // an empty string before the wanted one ends the string area
          if (last_was_nul && b == 8'd0) begin
            end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
            return;
          end
          if (b == 8'd0) begin
            wanted_string--;
            last_was_nul = 1'b1;
          end else begin
            last_was_nul = 1'b0;
          end
        end else begin
          if (b == 8'd0) begin
            end_walk(8'd0, 1'b0, OUT_FOUND);
            return;
          end
          last_was_nul = 1'b0;
          post(b, 1'b1, OUT_WALKING, 1'b0);
        end
      end
      default: begin
        end_walk(8'd0, 1'b0, OUT_NOT_FOUND);
        return;
      end
    endcase
    walk_off = 17'(a + 1);
  endtask

  // Track register writes and table bytes as the block takes them
  always @(posedge clk) begin
    if (rst) begin
      reset_walk();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) walk_byte(in_ch.table_byte, in_ch.first_byte);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_replies
    lookup_reply_t due;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (lookup_replies.size() == 0) begin
        $display("%0t: result with none expected: byte %h valid %b outcome %0d done %b",
                 $time, out_ch.out_byte, out_ch.byte_valid, out_ch.outcome, out_ch.done_res);
        mismatch_count++;
      end else begin
        due = lookup_replies.pop_front();
        compare_field("out_byte", out_ch.out_byte, due.data);
        compare_field("byte_valid", {7'd0, out_ch.byte_valid}, {7'd0, due.data_ok});
        compare_field("outcome", {6'd0, out_ch.outcome}, {6'd0, due.verdict});
        compare_field("done_res", {7'd0, out_ch.done_res}, {7'd0, due.last});
      end
    end
  end

  // Stall the result side at random, or hold it off for a requested stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (receiver_hold_req != 0) begin
      receiver_hold_left = receiver_hold_req;
      receiver_hold_req = 0;
      out_ch.ready <= 1'b0;
    end else if (receiver_hold_left != 0) begin
      receiver_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.table_byte <= b;
    in_ch.first_byte <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_table(input int cnt);
    for (int i = 0; i < cnt; i++) send_byte(table_buf[i], i == 0);
  endtask

  // Drop valid and wait until every result is in and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (lookup_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic write_live(input reg_index_t idx, input logic [15:0] v);
    settle();
    write_reg(idx, v);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_query(input query_t q);
    settle();
    write_reg(REG_QUERY_KIND, {15'd0, q.string_mode});
    write_reg(REG_TARGET_TYPE, {8'd0, q.type_id});
    write_reg(REG_FIELD_OFFSET, {8'd0, q.offset});
    write_reg(REG_FIELD_LENGTH, {8'd0, q.field_len});
    write_reg(REG_TABLE_LENGTH, q.table_len);
    write_reg(REG_STRUCTURE_COUNT, q.count);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic query_t make_query(input logic sm, input logic [7:0] t, input logic [7:0] o,
                                        input logic [7:0] l, input logic [15:0] tl,
                                        input logic [15:0] c);
    query_t q;
    q.string_mode = sm;
    q.type_id = t;
    q.offset = o;
    q.field_len = l;
    q.table_len = tl;
    q.count = c;
    return q;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic pick_query(output query_t q);
    int r;
    q.string_mode = 1'($urandom_range(1, 0));
    r = $urandom_range(9, 0);
    q.type_id = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(255, 0));
    r = $urandom_range(19, 0);
    q.offset = (r == 0) ? 8'($urandom_range(1, 0)) :
               (r == 1) ? 8'($urandom_range(255, 250)) : 8'($urandom_range(12, 2));
    r = $urandom_range(19, 0);
    q.field_len = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF :
                  (r == 2) ? 8'(255 - q.offset) : 8'($urandom_range(6, 1));
    q.table_len = 16'd0;
    q.count = 16'd0;
  endtask

  // Lay out a table of structures shaped so that some of them match the query
  task automatic build_table(inout query_t q);
    int n, len, nstr, slen, fend, sz, r;
    logic [7:0] kind;
    table_buf.delete();
    fend = q.offset + q.field_len;
    n = $urandom_range(4, 1);
    for (int s = 0; s < n; s++) begin
      kind = ($urandom_range(1, 0) == 1) ? q.type_id : 8'($urandom_range(255, 0));
      nstr = $urandom_range(3, 0);
      if (kind == q.type_id && !q.string_mode && fend <= 255)
        len = fend + $urandom_range(3, 0);
      else if (kind == q.type_id && q.string_mode)
        len = q.offset + 1 + $urandom_range(3, 0);
      else
        len = $urandom_range(20, 4);
      if (len > 255) len = 255;
      if (len < 4) len = 4;
      if ($urandom_range(29, 0) == 0) len = $urandom_range(3, 0);
      table_buf.push_back(kind);
      table_buf.push_back(8'(len));
      table_buf.push_back(8'($urandom_range(255, 0)));
      table_buf.push_back(8'($urandom_range(255, 0)));
      for (int p = 4; p < len; p++) begin
        r = $urandom_range(9, 0);
        if (q.string_mode && p == q.offset)
          table_buf.push_back((r == 0) ? 8'd0 : (r == 1) ? 8'($urandom_range(255, 0)) :
                              8'($urandom_range(nstr + 1, 1)));
        else
          table_buf.push_back(8'($urandom_range(255, 0)));
      end
      // string area, closed by a double NUL
      if (nstr == 0) table_buf.push_back(8'd0);
      for (int k = 0; k < nstr; k++) begin
        slen = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(5, 1);
        repeat (slen) table_buf.push_back(8'($urandom_range(255, 1)));
        table_buf.push_back(8'd0);
      end
      table_buf.push_back(8'd0);
    end
    if ($urandom_range(1, 0) == 1) begin
      table_buf.push_back(END_MARK_TYPE);
      table_buf.push_back(8'd4);
      table_buf.push_back(8'($urandom_range(255, 0)));
      table_buf.push_back(8'($urandom_range(255, 0)));
      table_buf.push_back(8'd0);
      table_buf.push_back(8'd0);
    end
    sz = table_buf.size();
    r = $urandom_range(19, 0);
    if (r < 14) q.table_len = 16'(sz);
    else if (r < 17) q.table_len = (sz > 8) ? 16'(sz - $urandom_range(8, 1)) : 16'd0;
    else if (r < 19) q.table_len = 16'hFFFF;
    else q.table_len = 16'($urandom_range(sz, 0));
    q.count = ($urandom_range(3, 0) != 0) ? 16'hFFFF : 16'($urandom_range(n + 1, 0));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_defaults_and_ignored();
    // empty table after reset, then a byte with no walk running
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_low_offset();
    program_query(make_query(1'b0, 8'd0, 8'd1, 8'd1, 16'd64, 16'hFFFF));
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_end_mark_and_short_length();
    program_query(make_query(1'b0, 8'd0, 8'd4, 8'd1, 16'd64, 16'hFFFF));
    send_byte(END_MARK_TYPE, 1'b1);
    send_byte(8'd3, 1'b1);
    send_byte(8'd2, 1'b0);
  endtask

  task automatic test_data_field_live_length();
    // widen the field mid-walk: it then runs to the end of the formatted area
    program_query(make_query(1'b0, 8'd5, 8'd4, 8'd2, 16'd16, 16'd1));
    table_buf = '{8'h05, 8'h08, 8'h34, 8'h12};
    send_table(4);
    write_live(REG_FIELD_LENGTH, 16'd200);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
  endtask

  task automatic test_zero_length();
    program_query(make_query(1'b0, 8'd5, 8'd4, 8'd0, 16'd16, 16'd1));
    table_buf = '{8'h05, 8'h08};
    send_table(2);
  endtask

  task automatic test_string_lookup();
    program_query(make_query(1'b1, 8'd9, 8'd4, 8'd1, 16'd12, 16'd2));
    table_buf = '{8'h09, 8'h06, 8'h00, 8'h01, 8'h02, 8'h55,
                  8'h41, 8'h00, 8'h42, 8'h43, 8'h00};
    send_table(table_buf.size());
  endtask

  task automatic test_string_index_missed();
    // move the index offset behind the walk so the string number never arrives
    program_query(make_query(1'b1, 8'd9, 8'd5, 8'd1, 16'd12, 16'd2));
    table_buf = '{8'h09, 8'h06, 8'h00, 8'h01};
    send_table(4);
    write_live(REG_FIELD_OFFSET, 16'd2);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  task automatic test_backpressure();
    program_query(make_query(1'b0, 8'h2A, 8'd4, 8'd40, 16'd100, 16'd3));
    table_buf = '{8'h2A, 8'd44, 8'h01, 8'h02};
    repeat (40) table_buf.push_back(8'($urandom_range(255, 0)));
    table_buf.push_back(8'd0);
    table_buf.push_back(8'd0);
    // hold the result side while the sender keeps offering the table
    receiver_hold_req = 150;
    send_table(table_buf.size());
    settle();
  endtask

  task automatic test_random_tables();
    query_t q;
    int first_count, progress, cut, r;
    logic have_query;
    have_query = 1'b0;
    first_count = walked_bytes;
    while (walked_bytes - first_count < 1450) begin
      progress = (walked_bytes - first_count) * 4 / 1450;
      case (progress)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
      r = $urandom_range(11, 0);
      if (r == 0) begin
        // noise: random bytes with the odd walk start among them
        repeat ($urandom_range(20, 4))
          send_byte(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
      end else begin
        if (r > 2 || !have_query) begin
          pick_query(q);
          build_table(q);
          program_query(q);
          have_query = 1'b1;
        end else begin
          // keep the query and restart the walk straight away
          build_table(q);
        end
        cut = ($urandom_range(7, 0) == 0) ? $urandom_range(table_buf.size(), 1)
                                          : table_buf.size();
        send_table(cut);
        if ($urandom_range(5, 0) == 0) settle();
      end
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.table_byte <= 8'd0;
    in_ch.first_byte <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_QUERY_KIND;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_defaults_and_ignored();
    test_low_offset();
    test_end_mark_and_short_length();
    test_data_field_live_length();
    test_zero_length();
    test_string_lookup();
    test_string_index_missed();
    test_backpressure();
    test_random_tables();

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && lookup_replies.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
